### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, codes and constants shared by the stuffed frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned MAX_DATA = 8;

	localparam logic [7:0] SYNC_BYTE = 8'hEE;
	localparam logic [7:0] ESC_BYTE  = 8'hEA;
	localparam logic [7:0] ESC_SYNC  = 8'hEB;
	localparam logic [7:0] ESC_ESC   = 8'hEC;
	localparam logic [7:0] NOT_MASK  = 8'hFF;

	localparam logic [7:0] CMD_01 = 8'h01;
	localparam logic [7:0] CMD_02 = 8'h02;
	localparam logic [7:0] CMD_03 = 8'h03;
	localparam logic [7:0] CMD_04 = 8'h04;
	localparam logic [7:0] CMD_11 = 8'h11;
	localparam logic [7:0] CMD_22 = 8'h22;
	localparam logic [7:0] CMD_33 = 8'h33;
	localparam logic [7:0] CMD_44 = 8'h44;
	localparam logic [7:0] CMD_55 = 8'h55;
	localparam logic [7:0] CMD_66 = 8'h66;

	localparam logic [3:0] POS_LENGTH  = 4'd1;
	localparam logic [3:0] POS_NOTLEN  = 4'd2;
	localparam logic [3:0] POS_COMMAND = 4'd3;
	localparam logic [3:0] POS_DATA    = 4'd4;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_LENGTH  = 3'd1,
		STAT_BAD_NOTLEN  = 3'd2,
		STAT_BAD_ESCAPE  = 3'd3,
		STAT_BAD_CHECK   = 3'd4,
		STAT_BAD_COMMAND = 3'd5
	} status_t;

	typedef struct packed {
		logic        in_frame;
		logic [3:0]  position;
		logic [3:0]  frame_length;
		logic        escape_pending;
		logic [7:0]  command_byte;
		logic [15:0] parity_word;
		logic [7:0]  check_high;
	} frame_state_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  command;
		logic [3:0]  data_length;
		logic [63:0] payload;
	} frame_result_t;

	typedef struct packed {
		logic       en;
		logic [2:0] addr;
		logic [7:0] data;
	} store_write_t;

endpackage

### hw/rtl/stuffed_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_core
// Byte-stuffed frame receiver with parity check word and command check.
// ----------------------------------------------------------------------------
//  channel | signals                                    | transfer
//  rx      | rx_valid, rx_stall, rx_byte                | one raw byte
//  res     | res_valid, res_stall, status, command,     | one frame outcome
//          | data_length, payload                       |
//
// One byte per cycle unless rx_stall is high; a byte is registered, decoded
// against the frame state and its outcome, if any, lands in the result register.
// arst_n clears the frame state and both valid flags; the data store is not reset.
// A stalled full result register holds the byte stage, which then stalls rx.
module stuffed_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [7:0]  command,
	output logic [3:0]  data_length,
	output logic [63:0] payload
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	sfr_pkg::frame_state_t  state_q;
	sfr_pkg::frame_state_t  state_nxt;
	sfr_pkg::store_write_t  wr;
	logic                   done;
	sfr_pkg::frame_result_t result;
	sfr_pkg::frame_result_t result_q;
	logic                   res_valid_q;
	logic [7:0]             store_q [sfr_pkg::MAX_DATA];

	assign advance  = valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	sfr_decoder u_decoder (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.store   (store_q),
		.nxt     (state_nxt),
		.wr      (wr),
		.done    (done),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			result_q <= result;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = result_q.status;
	assign command     = result_q.command;
	assign data_length = result_q.data_length;
	assign payload     = result_q.payload;

endmodule

### hw/rtl/sfr_decoder.sv
// ----------------------------------------------------------------------------
// sfr_decoder
// Per-byte deframing step: header checks, unstuffing, parity and frame close.
// ----------------------------------------------------------------------------
module sfr_decoder (
	input  logic [7:0]            rx_byte,
	input  sfr_pkg::frame_state_t cur,
	input  logic [7:0]            store [sfr_pkg::MAX_DATA],
	output sfr_pkg::frame_state_t nxt,
	output sfr_pkg::store_write_t wr,
	output logic                  done,
	output sfr_pkg::frame_result_t result
);

	logic [4:0]  pos_w;
	logic [4:0]  data_end;
	logic        in_data;
	logic        at_check_high;
	logic        add_en;
	logic [3:0]  add_k;
	logic [7:0]  add_b;
	logic [7:0]  dec_b;
	logic        dec_ok;
	logic        cmd_known;
	logic [63:0] pay;
	sfr_pkg::frame_state_t base;

	assign pos_w         = {1'b0, cur.position};
	assign data_end      = 5'(sfr_pkg::POS_DATA) + {1'b0, cur.frame_length};
	assign in_data       = (cur.position >= sfr_pkg::POS_DATA) && (pos_w < data_end);
	assign at_check_high = (pos_w == data_end);

	always_comb begin
		case (cur.command_byte) inside
			[sfr_pkg::CMD_01:sfr_pkg::CMD_04], sfr_pkg::CMD_11, sfr_pkg::CMD_22,
			sfr_pkg::CMD_33, sfr_pkg::CMD_44, sfr_pkg::CMD_55,
			sfr_pkg::CMD_66: cmd_known = 1'b1;
			default: cmd_known = 1'b0;
		endcase
	end

	always_comb begin
		pay = '0;
		for (int i = 0; i < int'(sfr_pkg::MAX_DATA); i++) begin
			if (4'(i) < cur.frame_length) begin
				pay[8*i +: 8] = store[i];
			end
		end
	end

	always_comb begin
		dec_ok = 1'b1;
		dec_b  = rx_byte;
		if (cur.escape_pending) begin
			if (rx_byte == sfr_pkg::ESC_SYNC) begin
				dec_b = sfr_pkg::SYNC_BYTE;
			end else if (rx_byte == sfr_pkg::ESC_ESC) begin
				dec_b = sfr_pkg::ESC_BYTE;
			end else begin
				dec_ok = 1'b0;
			end
		end
	end

	always_comb begin
		base = cur;
		base.in_frame       = 1'b0;
		base.position       = '0;
		base.escape_pending = 1'b0;

		nxt         = cur;
		wr          = '0;
		done        = 1'b0;
		result      = '0;
		add_en      = 1'b0;
		add_k       = cur.position;
		add_b       = rx_byte;

		if (rx_byte == sfr_pkg::SYNC_BYTE) begin
			nxt.in_frame       = 1'b1;
			nxt.position       = sfr_pkg::POS_LENGTH;
			nxt.frame_length   = '0;
			nxt.escape_pending = 1'b0;
			nxt.command_byte   = '0;
			nxt.parity_word    = {^sfr_pkg::SYNC_BYTE, 15'd0};
			nxt.check_high     = '0;
		end else if (cur.in_frame) begin
			if (cur.position == sfr_pkg::POS_LENGTH) begin
				if (rx_byte > 8'(sfr_pkg::MAX_DATA)) begin
					done          = 1'b1;
					result.status = sfr_pkg::STAT_BAD_LENGTH;
					nxt           = base;
				end else begin
					nxt.frame_length = rx_byte[3:0];
					nxt.position     = sfr_pkg::POS_NOTLEN;
					add_en           = 1'b1;
				end
			end else if (cur.position == sfr_pkg::POS_NOTLEN) begin
				if ((rx_byte ^ {4'd0, cur.frame_length}) != sfr_pkg::NOT_MASK) begin
					done          = 1'b1;
					result.status = sfr_pkg::STAT_BAD_NOTLEN;
					nxt           = base;
				end else begin
					nxt.position = sfr_pkg::POS_COMMAND;
					add_en       = 1'b1;
				end
			end else if (cur.position == sfr_pkg::POS_COMMAND) begin
				nxt.command_byte = rx_byte;
				nxt.position     = sfr_pkg::POS_DATA;
				add_en           = 1'b1;
			end else if (in_data) begin
				if (cur.escape_pending) begin
					if (!dec_ok) begin
						done          = 1'b1;
						result.status = sfr_pkg::STAT_BAD_ESCAPE;
						nxt           = base;
					end else begin
						nxt.escape_pending = 1'b0;
						nxt.position       = cur.position + 4'd1;
						wr.en              = 1'b1;
						add_en             = 1'b1;
						add_b              = dec_b;
					end
				end else if (rx_byte == sfr_pkg::ESC_BYTE) begin
					nxt.escape_pending = 1'b1;
				end else begin
					nxt.position = cur.position + 4'd1;
					wr.en        = 1'b1;
					add_en       = 1'b1;
				end
			end else if (at_check_high) begin
				nxt.check_high = rx_byte;
				nxt.position   = cur.position + 4'd1;
			end else begin
				done = 1'b1;
				nxt  = base;
				if ({cur.check_high, rx_byte} != cur.parity_word) begin
					result.status = sfr_pkg::STAT_BAD_CHECK;
				end else if (!cmd_known) begin
					result.status = sfr_pkg::STAT_BAD_COMMAND;
				end else begin
					result.status      = sfr_pkg::STAT_OK;
					result.command     = cur.command_byte;
					result.data_length = cur.frame_length;
					result.payload     = pay;
				end
			end
		end

		wr.addr = 3'(cur.position - sfr_pkg::POS_DATA);
		wr.data = dec_b;
		if (add_en && (^add_b)) begin
			nxt.parity_word[4'd15 - add_k] = 1'b1;
		end
	end

endmodule

### tb/sv/frame_checker.sv
// ----------------------------------------------------------------------------
// frame_checker
// Watches the byte and result channels of the stuffed frame receiver, keeps
// its own model of the frame state, predicts the outcome of every accepted
// byte and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_checker
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [2:0]  status,
	input  logic [7:0]  command,
	input  logic [3:0]  data_length,
	input  logic [63:0] payload,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        in_frame;
	logic [3:0]  pos;
	logic [3:0]  flen;
	logic        esc;
	logic [7:0]  cmd_b;
	logic [7:0]  chk_hi;
	logic [15:0] par;
	logic [7:0]  store [8];

	frame_result_t outcome_q[$];

	function automatic bit known_command(input logic [7:0] c);
		case (c)
			CMD_01, CMD_02, CMD_03, CMD_04, CMD_11,
			CMD_22, CMD_33, CMD_44, CMD_55, CMD_66: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic close_frame(input status_t st);
		frame_result_t r;
		r = '0;
		r.status = st;
		if (st == STAT_OK) begin
			r.command = cmd_b;
			r.data_length = flen;
			for (int i = 0; i < flen; i++)
				r.payload[8*i +: 8] = store[i];
		end
		outcome_q.push_back(r);
		in_frame = 1'b0;
		pos = '0;
		esc = 1'b0;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [7:0] d;
		if (b == SYNC_BYTE) begin
			in_frame = 1'b1;
			pos = POS_LENGTH;
			flen = '0;
			esc = 1'b0;
			cmd_b = '0;
			chk_hi = '0;
			par = '0;
			par[15] = ^SYNC_BYTE;
		end else if (!in_frame) begin
		end else if (pos == POS_LENGTH) begin
			if (b > MAX_DATA) begin
				close_frame(STAT_BAD_LENGTH);
			end else begin
				flen = b[3:0];
				par[14] = ^b;
				pos = POS_NOTLEN;
			end
		end else if (pos == POS_NOTLEN) begin
			if ((b ^ {4'd0, flen}) != NOT_MASK) begin
				close_frame(STAT_BAD_NOTLEN);
			end else begin
				par[13] = ^b;
				pos = POS_COMMAND;
			end
		end else if (pos == POS_COMMAND) begin
			cmd_b = b;
			par[12] = ^b;
			pos = POS_DATA;
		end else if (pos < POS_DATA + flen) begin
			if (esc && b != ESC_SYNC && b != ESC_ESC) begin
				close_frame(STAT_BAD_ESCAPE);
			end else if (!esc && b == ESC_BYTE) begin
				esc = 1'b1;
			end else begin
				d = !esc ? b : (b == ESC_SYNC ? SYNC_BYTE : ESC_BYTE);
				esc = 1'b0;
				store[pos - POS_DATA] = d;
				par[15 - pos] = ^d;
				pos = pos + 4'd1;
			end
		end else if (pos == POS_DATA + flen) begin
			chk_hi = b;
			pos = pos + 4'd1;
		end else if ({chk_hi, b} != par) begin
			close_frame(STAT_BAD_CHECK);
		end else if (!known_command(cmd_b)) begin
			close_frame(STAT_BAD_COMMAND);
		end else begin
			close_frame(STAT_OK);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			in_frame = 1'b0;
			pos = '0;
			flen = '0;
			esc = 1'b0;
			cmd_b = '0;
			chk_hi = '0;
			par = '0;
			outcome_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// compare the result transfer before predicting this edge's byte transfer
			if (res_valid && !res_stall) begin
				if (outcome_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result status %0d command %h length %0d payload %h",
							$time, status, command, data_length, payload);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (status != want.status || command != want.command ||
							data_length != want.data_length || payload != want.payload) begin
						if (errors < 10) begin
							$write("%0t: mismatch status %0d/%0d command %h/%h",
								$time, want.status, status, want.command, command);
							$display(" length %0d/%0d payload %h/%h (expected/actual)",
								want.data_length, data_length, want.payload, payload);
						end
						errors++;
					end
				end
			end
			if (rx_valid && !rx_stall)
				decode_byte(rx_byte);
			outstanding = outcome_q.size();
		end
	end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raw byte streams into the stuffed frame receiver: directed frames for
// every status, command and escape case, a long result stall that backs the
// block up, then random frames and noise under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	typedef enum int {PH_NONE, PH_SEND, PH_STALL, PH_BOTH} idle_phase_e;

	localparam int PHASE_BYTES = 230;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_stall;
	logic [2:0]  status;
	logic [7:0]  command;
	logic [3:0]  data_length;
	logic [63:0] payload;
	int          errors;
	int          outstanding;

	idle_phase_e phase = PH_NONE;
	bit          hold_req = 1'b0;
	logic [7:0]  tx_q[$];

	always #6 clk = ~clk;

	stuffed_frame_receiver_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.command     (command),
		.data_length (data_length),
		.payload     (payload)
	);

	frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.command     (command),
		.data_length (data_length),
		.payload     (payload),
		.errors      (errors),
		.outstanding (outstanding)
	);

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [7:0] known_command_at(input int i);
		case (i)
			0: return CMD_01;
			1: return CMD_02;
			2: return CMD_03;
			3: return CMD_04;
			4: return CMD_11;
			5: return CMD_22;
			6: return CMD_33;
			7: return CMD_44;
			8: return CMD_55;
			default: return CMD_66;
		endcase
	endfunction

	task automatic add_frame(input int len, input logic [7:0] cmd, input logic [63:0] data,
			input bit bad_check, input int bad_esc_at);
		logic [15:0] word;
		logic [7:0]  lb;
		logic [7:0]  d;
		logic [7:0]  junk;
		lb = 8'(len);
		word = '0;
		word[15] = ^SYNC_BYTE;
		word[14] = ^lb;
		word[13] = ^(~lb);
		word[12] = ^cmd;
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(lb);
		tx_q.push_back(~lb);
		tx_q.push_back(cmd);
		for (int i = 0; i < len; i++) begin
			d = data[8*i +: 8];
			if (i == bad_esc_at) begin
				junk = 8'($urandom_range(255));
				while (junk == ESC_SYNC || junk == ESC_ESC || junk == SYNC_BYTE)
					junk = 8'($urandom_range(255));
				tx_q.push_back(ESC_BYTE);
				tx_q.push_back(junk);
				return;
			end
			word[11 - i] = ^d;
			if (d == SYNC_BYTE) begin
				tx_q.push_back(ESC_BYTE);
				tx_q.push_back(ESC_SYNC);
			end else if (d == ESC_BYTE) begin
				tx_q.push_back(ESC_BYTE);
				tx_q.push_back(ESC_ESC);
			end else begin
				tx_q.push_back(d);
			end
		end
		if (bad_check)
			word = word ^ 16'($urandom_range(1, 16'hFFFF));
		tx_q.push_back(word[15:8]);
		tx_q.push_back(word[7:0]);
	endtask

	task automatic add_random_frame();
		int         kind;
		int         len;
		logic [7:0] cmd;
		logic [7:0] lb;
		logic [63:0] data;
		len = $urandom_range(8);
		cmd = roll(50) ? known_command_at($urandom_range(9)) : 8'($urandom_range(255));
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(9))
				0, 1: data[8*i +: 8] = SYNC_BYTE;
				2: data[8*i +: 8] = ESC_BYTE;
				3: data[8*i +: 8] = ESC_SYNC;
				4: data[8*i +: 8] = ESC_ESC;
				default: data[8*i +: 8] = 8'($urandom_range(255));
			endcase
		end
		kind = $urandom_range(99);
		if (kind < 70) begin
			add_frame(len, cmd, data, 1'b0, -1);
		end else if (kind < 78) begin
			add_frame(len, cmd, data, 1'b1, -1);
		end else if (kind < 84) begin
			len = $urandom_range(1, 8);
			add_frame(len, cmd, data, 1'b0, $urandom_range(len - 1));
		end else if (kind < 88) begin
			add_frame(len, cmd, data, roll(50), -1);
			repeat ($urandom_range(1, tx_q.size() - 1))
				void'(tx_q.pop_back());
		end else if (kind < 92) begin
			tx_q.push_back(SYNC_BYTE);
			tx_q.push_back(8'($urandom_range(MAX_DATA + 1, 255)));
		end else if (kind < 96) begin
			lb = 8'($urandom_range(255));
			if (lb == ~8'(len))
				lb[0] = ~lb[0];
			tx_q.push_back(SYNC_BYTE);
			tx_q.push_back(8'(len));
			tx_q.push_back(lb);
		end else begin
			repeat ($urandom_range(1, 4))
				tx_q.push_back(8'($urandom_range(255)));
		end
	endtask

	// call at a falling edge; returns at a falling edge with valid still high
	task automatic send_stream();
		logic [7:0] b;
		while (tx_q.size() != 0) begin
			b = tx_q.pop_front();
			while ((phase == PH_SEND && roll(72)) || (phase == PH_BOTH && roll(35))) begin
				rx_valid <= 1'b0;
				@(negedge clk);
			end
			rx_valid <= 1'b1;
			rx_byte <= b;
			@(posedge clk);
			while (rx_stall)
				@(posedge clk);
			@(negedge clk);
		end
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= (phase == PH_STALL && roll(72)) || (phase == PH_BOTH && roll(35));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin : stimulus
		int sent;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_q = '{8'h00, 8'hFF, ESC_SYNC, ESC_BYTE, 8'h41};
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(8'h09);
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(8'hFF);
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(ESC_BYTE);
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(8'h05);
		tx_q.push_back(8'h05);
		add_frame(0, CMD_01, '0, 1'b0, -1);
		for (int i = 0; i < 10; i++)
			add_frame(i % 4, known_command_at(i), {$urandom, $urandom}, 1'b0, -1);
		add_frame(8, CMD_66, 64'hAA55_ECEB_FF00_EAEE, 1'b0, -1);
		add_frame(1, 8'h00, 64'h5A, 1'b0, -1);
		add_frame(1, 8'h05, 64'hA5, 1'b0, -1);
		add_frame(2, ESC_BYTE, 64'hEAEE, 1'b0, -1);
		add_frame(0, 8'hFF, '0, 1'b0, -1);
		add_frame(2, CMD_11, 64'h1234, 1'b1, -1);
		add_frame(3, CMD_22, 64'h00FF00, 1'b0, 1);
		add_frame(4, CMD_33, 64'h4433_2211, 1'b0, -1);
		repeat (4) void'(tx_q.pop_back());
		tx_q.push_back(SYNC_BYTE);
		tx_q.push_back(8'h02);
		tx_q.push_back(8'hFD);
		tx_q.push_back(CMD_44);
		tx_q.push_back(ESC_BYTE);
		add_frame(1, CMD_55, 64'h77, 1'b0, -1);
		void'(tx_q.pop_back());
		add_frame(2, CMD_03, 64'h8001, 1'b0, -1);
		repeat (2) void'(tx_q.pop_back());
		tx_q.push_back(SYNC_BYTE);
		add_frame(8, CMD_02, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, -1);
		send_stream();

		hold_req = 1'b1;
		repeat (40) begin
			tx_q.push_back(SYNC_BYTE);
			tx_q.push_back(8'h09);
		end
		send_stream();

		for (int p = 0; p < 4; p++) begin
			phase = idle_phase_e'(p);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				add_random_frame();
				sent += tx_q.size();
				send_stream();
			end
		end
		rx_valid <= 1'b0;
		phase = PH_NONE;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
